@@ hdl/rlpe_pkg.sv @@
// Shared constants, types and helpers of the RGB LED pulse-width encoder.
package rlpe_pkg;

    localparam int CHAN_W          = 8;
    localparam int WIDTH_W         = 8;
    localparam int PROD_W          = 2 * CHAN_W;
    localparam int PULSES_PER_LED  = 3 * CHAN_W;
    localparam int BIT_CNT_W       = $clog2(PULSES_PER_LED);
    localparam int MAX_GAP         = 40;
    localparam int GAP_CNT_W       = $clog2(MAX_GAP + 1);
    localparam int RESET_PULSES_DEF = 40;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_WIDTH  = 2'd2;

    localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST      = 8'd255;
    localparam logic [WIDTH_W-1:0] ZERO_HIGH_WIDTH_RST = 8'd96;
    localparam logic [WIDTH_W-1:0] ONE_HIGH_WIDTH_RST  = 8'd192;

    typedef struct packed {
        logic [CHAN_W-1:0]  brightness;
        logic [WIDTH_W-1:0] zero_high_width;
        logic [WIDTH_W-1:0] one_high_width;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
        logic              final_led;
    } scaled_t;

    // floor(p / 255) for p up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] sum;
        sum = (PROD_W+1)'(p) + (PROD_W+1)'(p[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
        return sum[PROD_W-1:CHAN_W];
    endfunction

endpackage

@@ hdl/rlpe_led_if.sv @@
// Request channel carrying one LED colour.
interface rlpe_led_if;
    logic                       valid;
    logic                       ready;
    logic [rlpe_pkg::CHAN_W-1:0] red;
    logic [rlpe_pkg::CHAN_W-1:0] green;
    logic [rlpe_pkg::CHAN_W-1:0] blue;
    logic                       final_led;

    modport source (output valid, red, green, blue, final_led, input ready);
    modport sink   (input valid, red, green, blue, final_led, output ready);
endinterface

@@ hdl/rlpe_pulse_if.sv @@
// Request channel carrying one pulse-width code.
interface rlpe_pulse_if;
    logic                         valid;
    logic                         ready;
    logic [rlpe_pkg::WIDTH_W-1:0] pulse_width;
    logic                         run_end;

    modport source (output valid, pulse_width, run_end, input ready);
    modport sink   (input valid, pulse_width, run_end, output ready);
endinterface

@@ hdl/rlpe_scale.sv @@
// Two-stage brightness scaler: multiply, then divide by 255.
module rlpe_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  rlpe_pkg::cfg_t      cfg,
    rlpe_led_if.sink            led,
    output logic                item_valid,
    output rlpe_pkg::scaled_t   item,
    input  logic                item_ready
);

    logic                          s1_valid_reg, s1_valid_next;
    logic [rlpe_pkg::PROD_W-1:0]   prod_g_reg, prod_r_reg, prod_b_reg;
    logic                          s1_final_reg;
    logic                          s2_valid_reg, s2_valid_next;
    rlpe_pkg::scaled_t             s2_reg;
    logic                          s1_adv, s2_adv;

    assign s2_adv    = !s2_valid_reg || item_ready;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign led.ready = s1_adv;

    assign s1_valid_next = s1_adv ? led.valid : s1_valid_reg;
    assign s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            prod_g_reg   <= rlpe_pkg::PROD_W'(led.green) * rlpe_pkg::PROD_W'(cfg.brightness);
            prod_r_reg   <= rlpe_pkg::PROD_W'(led.red) * rlpe_pkg::PROD_W'(cfg.brightness);
            prod_b_reg   <= rlpe_pkg::PROD_W'(led.blue) * rlpe_pkg::PROD_W'(cfg.brightness);
            s1_final_reg <= led.final_led;
        end
        if (s2_adv)
        begin
            s2_reg.green     <= rlpe_pkg::div255(prod_g_reg);
            s2_reg.red       <= rlpe_pkg::div255(prod_r_reg);
            s2_reg.blue      <= rlpe_pkg::div255(prod_b_reg);
            s2_reg.final_led <= s1_final_reg;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_reg;

endmodule

@@ hdl/rlpe_serial.sv @@
// Pulse serializer: 24 data pulses per LED, latch gap after the final LED if GAP_PULSES > 0.
module rlpe_serial #(
    parameter int GAP_PULSES = rlpe_pkg::RESET_PULSES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rlpe_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  rlpe_pkg::scaled_t   item,
    output logic                item_ready,
    rlpe_pulse_if.source        pulse
);

    localparam int GAP      = (GAP_PULSES > rlpe_pkg::MAX_GAP) ? rlpe_pkg::MAX_GAP : GAP_PULSES;
    localparam bit HAS_GAP  = (GAP != 0);
    localparam logic [rlpe_pkg::GAP_CNT_W-1:0] GAP_LAST =
        rlpe_pkg::GAP_CNT_W'((GAP == 0) ? 0 : GAP - 1);
    localparam logic [rlpe_pkg::BIT_CNT_W-1:0] LAST_BIT =
        rlpe_pkg::BIT_CNT_W'(rlpe_pkg::PULSES_PER_LED - 1);
    localparam int DATA_W = rlpe_pkg::PULSES_PER_LED;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DATA = 3'b010,
        S_GAP  = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [DATA_W-1:0]                 data_reg, data_next;
    logic [rlpe_pkg::BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [rlpe_pkg::GAP_CNT_W-1:0]    gap_cnt_reg, gap_cnt_next;
    logic                              final_reg, final_next;
    logic                              out_valid_reg, out_valid_next;
    logic [rlpe_pkg::WIDTH_W-1:0]      pulse_width_reg;
    logic                              run_end_reg;
    logic [rlpe_pkg::WIDTH_W-1:0]      width_c;
    logic                              last_c;
    logic                              busy;
    logic                              emit;
    logic                              take;

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        if (state_reg == S_GAP)
        begin
            width_c = '0;
            last_c  = (gap_cnt_reg == GAP_LAST);
        end
        else
        begin
            width_c = data_reg[DATA_W-1] ? cfg.one_high_width : cfg.zero_high_width;
            last_c  = (bit_cnt_reg == LAST_BIT) && !(final_reg && HAS_GAP);
        end
        emit       = busy && (!out_valid_reg || pulse.ready);
        item_ready = !busy || (emit && last_c);
        take       = item_valid && item_ready;
    end

    always_comb
    begin
        state_next   = state_reg;
        data_next    = data_reg;
        bit_cnt_next = bit_cnt_reg;
        gap_cnt_next = gap_cnt_reg;
        final_next   = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DATA:
            begin
                if (emit)
                begin
                    data_next    = {data_reg[DATA_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == LAST_BIT)
                    begin
                        gap_cnt_next = '0;
                        state_next   = (final_reg && HAS_GAP) ? S_GAP : S_IDLE;
                    end
                end
            end
            S_GAP:
            begin
                if (emit)
                begin
                    gap_cnt_next = gap_cnt_reg + 1'b1;
                    if (gap_cnt_reg == GAP_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (take)
        begin
            data_next    = {item.green, item.red, item.blue};
            bit_cnt_next = '0;
            final_next   = item.final_led;
            state_next   = S_DATA;
        end
    end

    assign out_valid_next = emit ? 1'b1 : (pulse.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            gap_cnt_reg   <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            gap_cnt_reg   <= gap_cnt_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (emit)
        begin
            pulse_width_reg <= width_c;
            run_end_reg     <= last_c;
        end
    end

    assign pulse.valid       = out_valid_reg;
    assign pulse.pulse_width = pulse_width_reg;
    assign pulse.run_end     = run_end_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("serializer state not one-hot");

    a_gap_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAP) |-> (final_reg && HAS_GAP))
        else $error("latch gap without final LED");

    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAP) |-> (gap_cnt_reg <= GAP_LAST))
        else $error("latch gap counter overrun");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!busy || (emit && last_c)))
        else $error("new LED loaded over a running one");

endmodule

@@ hdl/rgb_led_pulse_width_encoder.sv @@
// RGB LED pulse-width encoder: config registers, scaler and pulse serializer.
// A request passes multiply, divide, serializer and output registers; 24 codes per LED.
// Throughput: one pulse code per cycle while pulse.ready is high, set by the single pulse
// serializer and its output register; a final LED adds RESET_PULSES (max 40) gap codes.
// Reset: rst_n asynchronous active low; clears the pipeline, serializer and output,
// and loads brightness 255, zero width 96, one width 192.
module rgb_led_pulse_width_encoder #(
    parameter int RESET_PULSES = rlpe_pkg::RESET_PULSES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rlpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rlpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    rlpe_led_if.sink                            led,
    rlpe_pulse_if.source                        pulse
);

    rlpe_pkg::cfg_t     cfg_reg, cfg_next;
    logic               item_valid;
    logic               item_ready;
    rlpe_pkg::scaled_t  item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rlpe_pkg::REG_BRIGHTNESS:
                    cfg_next.brightness = cfg_data[rlpe_pkg::CHAN_W-1:0];
                rlpe_pkg::REG_ZERO_HIGH_WIDTH:
                    cfg_next.zero_high_width = cfg_data[rlpe_pkg::WIDTH_W-1:0];
                rlpe_pkg::REG_ONE_HIGH_WIDTH:
                    cfg_next.one_high_width = cfg_data[rlpe_pkg::WIDTH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness      <= rlpe_pkg::BRIGHTNESS_RST;
            cfg_reg.zero_high_width <= rlpe_pkg::ZERO_HIGH_WIDTH_RST;
            cfg_reg.one_high_width  <= rlpe_pkg::ONE_HIGH_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rlpe_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .led        (led),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    rlpe_serial #(
        .GAP_PULSES (RESET_PULSES)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .pulse      (pulse)
    );

endmodule
